[rtl/stt_pkg.sv]
// Shared types, constants and helper functions for the source text tokenizer.
package stt_pkg;

  localparam int unsigned MAX_TOKEN_CHARS = 15;
  localparam int unsigned HEAD_BYTES = (MAX_TOKEN_CHARS < 8) ? MAX_TOKEN_CHARS : 8;
  localparam int unsigned KW_NUM = 5;
  localparam int unsigned LEN_MAX = 31;

  typedef enum logic [3:0] {
    TK_ASSIGN     = 4'd0,
    TK_LPAREN     = 4'd1,
    TK_RPAREN     = 4'd2,
    TK_LBRACE     = 4'd3,
    TK_RBRACE     = 4'd4,
    TK_COMMA      = 4'd5,
    TK_SEMICOLON  = 4'd6,
    TK_TYPE_KW    = 4'd7,
    TK_PRINT_KW   = 4'd8,
    TK_MAIN       = 4'd9,
    TK_RETURN_KW  = 4'd10,
    TK_IDENT      = 4'd11,
    TK_NUMBER     = 4'd12,
    TK_UNKNOWN    = 4'd13
  } token_kind_t;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_PUNCT,
    CLS_LETTER,
    CLS_DIGIT,
    CLS_OTHER,
    CLS_EOT
  } char_class_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_ALPHA,
    MODE_DIGIT
  } run_mode_t;

  // One classified input beat as it travels from the front end to the back end.
  typedef struct packed {
    char_class_t cls;
    logic [7:0]  data;
    logic [31:0] pos;
    token_kind_t punct;
  } cmd_t;

  // Keywords, first character in the low byte.
  localparam logic [5:0][7:0] KW_TEXT [KW_NUM] = '{
    48'h0000_0074_6E69,   // int
    48'h0000_6469_6F76,   // void
    48'h0074_6E69_7270,   // print
    48'h0000_6E69_616D,   // main
    48'h6E72_7574_6572    // return
  };
  localparam logic [4:0] KW_LEN [KW_NUM] = '{5'd3, 5'd4, 5'd5, 5'd4, 5'd6};
  localparam token_kind_t KW_KIND [KW_NUM] = '{
    TK_TYPE_KW, TK_TYPE_KW, TK_PRINT_KW, TK_MAIN, TK_RETURN_KW
  };

  // True when character b at position idx still agrees with keyword k.
  function automatic logic kw_step(input int unsigned k, input logic [4:0] idx,
                                   input logic [7:0] b);
    logic [2:0] sel;
    sel = idx[2:0];
    if (idx >= KW_LEN[k]) begin
      return 1'b0;
    end
    return KW_TEXT[k][sel] == b;
  endfunction

  function automatic char_class_t classify(input logic [7:0] b, input logic eot);
    char_class_t c;
    if (eot) begin
      c = CLS_EOT;
    end else if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
      c = CLS_SPACE;
    end else if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)) begin
      c = CLS_LETTER;
    end else if (b >= 8'h30 && b <= 8'h39) begin
      c = CLS_DIGIT;
    end else if (b == 8'h3D || b == 8'h28 || b == 8'h29 || b == 8'h7B ||
                 b == 8'h7D || b == 8'h2C || b == 8'h3B) begin
      c = CLS_PUNCT;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

  function automatic token_kind_t punct_kind(input logic [7:0] b);
    token_kind_t k;
    unique case (b)
      8'h3D:   k = TK_ASSIGN;
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h7B:   k = TK_LBRACE;
      8'h7D:   k = TK_RBRACE;
      8'h2C:   k = TK_COMMA;
      8'h3B:   k = TK_SEMICOLON;
      default: k = TK_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

[rtl/stt_front.sv]
// Front end: accepts text beats, tracks the byte offset and classifies each byte.
module stt_front (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    text_byte,
  input  logic          end_of_text,
  input  logic          text_valid,
  output logic          text_ready,
  output logic          push_valid,
  input  logic          push_ready,
  output stt_pkg::cmd_t push_cmd
);

  logic [31:0] byte_position;

  assign push_valid = text_valid;
  assign text_ready = push_ready;

  always_comb begin
    push_cmd.cls   = stt_pkg::classify(text_byte, end_of_text);
    push_cmd.data  = text_byte;
    push_cmd.pos   = byte_position;
    push_cmd.punct = stt_pkg::punct_kind(text_byte);
  end

  // End of text does not occupy a byte offset.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (text_valid && push_ready && !end_of_text) begin
      byte_position <= byte_position + 32'd1;
    end
  end

endmodule

[rtl/stt_queue.sv]
// Short command queue between the front end and the back end.
module stt_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  stt_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop,
  output stt_pkg::cmd_t pop_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  stt_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/stt_back.sv]
// Back end: keeps the open run, matches keywords and drives the token output register.
module stt_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  stt_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          token_valid,
  input  logic          token_ready,
  output logic [3:0]    token_kind,
  output logic [31:0]   start_pos,
  output logic [4:0]    token_length,
  output logic [63:0]   text_head,
  output logic          truncated,
  output logic          last_of_run
);

  stt_pkg::run_mode_t           mode, mode_next;
  logic [4:0]                   run_length, run_length_next;
  logic [31:0]                  run_start, run_start_next;
  logic                         run_over, run_over_next;
  logic [63:0]                  run_head, run_head_next;
  logic [stt_pkg::KW_NUM-1:0]   kw_match, kw_match_next;

  stt_pkg::token_kind_t flush_kind;
  stt_pkg::token_kind_t tok_kind;
  stt_pkg::token_kind_t kind_reg;
  logic [31:0]          tok_start;
  logic [4:0]           tok_len;
  logic [63:0]          tok_head;
  logic                 tok_trunc;
  logic                 tok_last;
  logic                 run_open;
  logic                 emit;
  logic                 take;
  logic                 start_run;
  logic                 append;
  logic                 load_ok;
  logic                 fire;
  logic                 load;

  assign run_open = (mode == stt_pkg::MODE_ALPHA) || (mode == stt_pkg::MODE_DIGIT);
  assign load_ok  = !token_valid || token_ready;

  always_comb begin
    flush_kind = stt_pkg::TK_IDENT;
    if (mode == stt_pkg::MODE_DIGIT) begin
      flush_kind = stt_pkg::TK_NUMBER;
    end else if (!run_over) begin
      for (int k = 0; k < stt_pkg::KW_NUM; k++) begin
        if (kw_match[k] && run_length == stt_pkg::KW_LEN[k]) begin
          flush_kind = stt_pkg::KW_KIND[k];
        end
      end
    end
  end

  // A byte that closes a run and is itself a token stays at the queue head;
  // the run is closed on this pass and the byte is handled from idle on the next.
  always_comb begin
    emit      = 1'b0;
    take      = 1'b0;
    start_run = 1'b0;
    append    = 1'b0;
    tok_kind  = flush_kind;
    tok_start = run_start;
    tok_len   = run_length;
    tok_head  = run_head;
    tok_trunc = run_over;
    tok_last  = 1'b1;
    mode_next       = mode;
    run_length_next = run_length;
    run_start_next  = run_start;
    run_over_next   = run_over;
    run_head_next   = run_head;
    kw_match_next   = kw_match;

    if (cmd.cls == stt_pkg::CLS_EOT) begin
      emit      = run_open;
      take      = 1'b1;
      mode_next = stt_pkg::MODE_IDLE;
      if (run_open) begin
        run_length_next = '0;
        run_over_next   = 1'b0;
      end
    end else if ((mode == stt_pkg::MODE_ALPHA && cmd.cls == stt_pkg::CLS_LETTER) ||
                 (mode == stt_pkg::MODE_DIGIT && cmd.cls == stt_pkg::CLS_DIGIT)) begin
      append = 1'b1;
      take   = 1'b1;
    end else if (run_open) begin
      emit            = 1'b1;
      mode_next       = stt_pkg::MODE_IDLE;
      run_length_next = '0;
      run_over_next   = 1'b0;
      if (cmd.cls == stt_pkg::CLS_PUNCT || cmd.cls == stt_pkg::CLS_OTHER) begin
        tok_last = 1'b0;
      end else begin
        take      = 1'b1;
        start_run = (cmd.cls == stt_pkg::CLS_LETTER) || (cmd.cls == stt_pkg::CLS_DIGIT);
      end
    end else begin
      take      = 1'b1;
      mode_next = stt_pkg::MODE_IDLE;
      tok_start = cmd.pos;
      tok_len   = 5'd1;
      tok_head  = {56'd0, cmd.data};
      tok_trunc = 1'b0;
      unique case (cmd.cls)
        stt_pkg::CLS_PUNCT: begin
          emit     = 1'b1;
          tok_kind = cmd.punct;
        end
        stt_pkg::CLS_OTHER: begin
          emit     = 1'b1;
          tok_kind = stt_pkg::TK_UNKNOWN;
        end
        stt_pkg::CLS_LETTER, stt_pkg::CLS_DIGIT: begin
          start_run = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (start_run) begin
      mode_next       = (cmd.cls == stt_pkg::CLS_LETTER) ? stt_pkg::MODE_ALPHA
                                                         : stt_pkg::MODE_DIGIT;
      run_length_next = 5'd1;
      run_over_next   = 1'b0;
      run_start_next  = cmd.pos;
      run_head_next   = {56'd0, cmd.data};
      for (int k = 0; k < stt_pkg::KW_NUM; k++) begin
        kw_match_next[k] = stt_pkg::kw_step(k, 5'd0, cmd.data);
      end
    end

    if (append) begin
      run_over_next   = run_over || (run_length >= 5'(stt_pkg::MAX_TOKEN_CHARS));
      run_length_next = (run_length == 5'(stt_pkg::LEN_MAX)) ? run_length
                                                             : run_length + 5'd1;
      if (run_length < 5'(stt_pkg::HEAD_BYTES)) begin
        run_head_next[{run_length[2:0], 3'b000} +: 8] = cmd.data;
      end
      for (int k = 0; k < stt_pkg::KW_NUM; k++) begin
        kw_match_next[k] = kw_match[k] && stt_pkg::kw_step(k, run_length, cmd.data);
      end
    end
  end

  assign fire    = cmd_valid && (!emit || load_ok);
  assign load    = fire && emit;
  assign cmd_pop = fire && take;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= stt_pkg::MODE_IDLE;
      run_length <= '0;
      run_start  <= '0;
      run_over   <= 1'b0;
    end else if (fire) begin
      mode       <= mode_next;
      run_length <= run_length_next;
      run_start  <= run_start_next;
      run_over   <= run_over_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      run_head <= run_head_next;
      kw_match <= kw_match_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (load) begin
      token_valid <= 1'b1;
    end else if (token_ready) begin
      token_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_reg     <= tok_kind;
      start_pos    <= tok_start;
      token_length <= tok_len;
      text_head    <= tok_head;
      truncated    <= tok_trunc;
      last_of_run  <= tok_last;
    end
  end

  assign token_kind = kind_reg;

  a_open_run_nonempty: assert property (@(posedge clk) disable iff (rst)
    (mode != stt_pkg::MODE_IDLE) |-> (run_length != 5'd0))
    else $error("open run with zero length");

  a_first_of_pair_is_run: assert property (@(posedge clk) disable iff (rst)
    (token_valid && !last_of_run) |->
      (token_kind >= 4'(stt_pkg::TK_TYPE_KW) && token_kind <= 4'(stt_pkg::TK_NUMBER)))
    else $error("non-final token is not a run token");

  a_trunc_len: assert property (@(posedge clk) disable iff (rst)
    (token_valid && truncated) |-> (token_length > 5'(stt_pkg::MAX_TOKEN_CHARS)))
    else $error("truncated token too short");

  a_single_char: assert property (@(posedge clk) disable iff (rst)
    (token_valid && (token_kind <= 4'(stt_pkg::TK_SEMICOLON) ||
                     token_kind == 4'(stt_pkg::TK_UNKNOWN))) |->
      (token_length == 5'd1 && !truncated))
    else $error("single character token with bad length");

  a_split_closes_run: assert property (@(posedge clk) disable iff (rst)
    (load && !tok_last) |=> (mode == stt_pkg::MODE_IDLE))
    else $error("run still open after flush");

endmodule

[rtl/source_text_tokenizer.sv]
// Top level of the source text tokenizer: front end, command queue and back end.
//
// Text enters one byte per beat on the text channel (text_valid/text_ready), with
// end_of_text marking a flush beat whose byte is ignored. Tokens leave one per beat
// on the token channel (token_valid/token_ready) with kind, start offset, length,
// the first eight characters and a truncation flag; last_of_run marks the final
// token caused by an input beat.
// A token is loaded into the output register once the beat that causes it is at
// the head of the command queue and the output register is free; an accepted beat
// is first registered in the queue, even when the queue is empty.
// Throughput: one input beat per cycle while text_ready is high. A byte that both
// ends a run and is a token by itself produces two tokens and stays at the queue
// head until both are loaded, as the output register takes one token per cycle.
// A stalled receiver holds the output register; the queue of QUEUE_DEPTH beats
// keeps accepting text until it fills, after which text_ready drops.
// Reset clears the open run, the byte offset and all valid flags; a new text can
// start right after reset.
module source_text_tokenizer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  input  logic        text_valid,
  output logic        text_ready,
  output logic        token_valid,
  input  logic        token_ready,
  output logic [3:0]  token_kind,
  output logic [31:0] start_pos,
  output logic [4:0]  token_length,
  output logic [63:0] text_head,
  output logic        truncated,
  output logic        last_of_run
);

  stt_pkg::cmd_t push_cmd;
  stt_pkg::cmd_t head_cmd;
  logic          push_valid;
  logic          push_ready;
  logic          head_valid;
  logic          head_pop;

  stt_front u_front (
    .clk         (clk),
    .rst         (rst),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .text_valid  (text_valid),
    .text_ready  (text_ready),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  stt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (head_valid),
    .pop        (head_pop),
    .pop_cmd    (head_cmd)
  );

  stt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (head_valid),
    .cmd          (head_cmd),
    .cmd_pop      (head_pop),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token_kind   (token_kind),
    .start_pos    (start_pos),
    .token_length (token_length),
    .text_head    (text_head),
    .truncated    (truncated),
    .last_of_run  (last_of_run)
  );

endmodule

[tb/sv/token_checker.sv]
// Checker for the source text tokenizer: tracks text beats, predicts tokens and compares them.
`timescale 1ns / 1ps

module token_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  input  logic        text_valid,
  input  logic        text_ready,
  input  logic        token_valid,
  input  logic        token_ready,
  input  logic [3:0]  token_kind,
  input  logic [31:0] start_pos,
  input  logic [4:0]  token_length,
  input  logic [63:0] text_head,
  input  logic        truncated,
  input  logic        last_of_run,
  input  logic        run_done,
  output int unsigned mismatch_count,
  output int unsigned tokens_pending,
  output int unsigned beats_seen,
  output int unsigned eot_seen,
  output int unsigned tokens_seen,
  output int unsigned long_seen,
  output logic [13:0] kinds_seen
);

  typedef struct packed {
    stt_pkg::token_kind_t kind;
    logic [31:0]          pos;
    logic [4:0]           len;
    logic [63:0]          head;
    logic                 trunc;
    logic                 last;
  } token_t;

  token_t             predicted_tokens [$];
  stt_pkg::run_mode_t run_mode;
  logic [7:0]         run_text [stt_pkg::MAX_TOKEN_CHARS];
  logic [4:0]         run_len;
  logic [31:0]        run_start;
  logic [31:0]        byte_pos;
  logic               run_over;
  logic               end_reported;

  function automatic int unsigned kept_count();
    return (run_len < stt_pkg::MAX_TOKEN_CHARS) ? run_len : stt_pkg::MAX_TOKEN_CHARS;
  endfunction

  // Keywords are matched on the kept letters, packed with the first letter on top so
  // that they line up with string literals.
  function automatic stt_pkg::token_kind_t word_kind();
    logic [47:0] word;
    int unsigned kept;
    kept = kept_count();
    if (run_mode == stt_pkg::MODE_DIGIT) return stt_pkg::TK_NUMBER;
    if (run_over || kept > 6) return stt_pkg::TK_IDENT;
    word = '0;
    for (int i = 0; i < kept; i++) word = {word[39:0], run_text[i]};
    unique case (word)
      "int", "void": return stt_pkg::TK_TYPE_KW;
      "print":       return stt_pkg::TK_PRINT_KW;
      "main":        return stt_pkg::TK_MAIN;
      "return":      return stt_pkg::TK_RETURN_KW;
      default:       return stt_pkg::TK_IDENT;
    endcase
  endfunction

  function automatic void grow_run(input logic [7:0] b);
    if (run_len < stt_pkg::MAX_TOKEN_CHARS) begin
      run_text[run_len] = b;
    end else begin
      run_over = 1'b1;
    end
    if (run_len != 5'd31) run_len = run_len + 5'd1;
  endfunction

  function automatic token_t close_run();
    token_t t;
    int unsigned kept;
    kept = kept_count();
    t.kind = word_kind();
    t.pos = run_start;
    t.len = run_len;
    t.head = '0;
    for (int i = 0; i < kept && i < 8; i++) t.head[8*i +: 8] = run_text[i];
    t.trunc = run_over;
    t.last = 1'b0;
    run_mode = stt_pkg::MODE_IDLE;
    run_len = '0;
    run_over = 1'b0;
    return t;
  endfunction

  function automatic token_t single_char(input logic [7:0] b, input logic [31:0] where);
    token_t t;
    unique case (b)
      "=":     t.kind = stt_pkg::TK_ASSIGN;
      "(":     t.kind = stt_pkg::TK_LPAREN;
      ")":     t.kind = stt_pkg::TK_RPAREN;
      "{":     t.kind = stt_pkg::TK_LBRACE;
      "}":     t.kind = stt_pkg::TK_RBRACE;
      ",":     t.kind = stt_pkg::TK_COMMA;
      ";":     t.kind = stt_pkg::TK_SEMICOLON;
      default: t.kind = stt_pkg::TK_UNKNOWN;
    endcase
    t.pos = where;
    t.len = 5'd1;
    t.head = {56'd0, b};
    t.trunc = 1'b0;
    t.last = 1'b0;
    return t;
  endfunction

  task automatic tokenize_beat(input logic [7:0] b, input logic eot);
    token_t      made [2];
    int unsigned n;
    logic        open_run;
    logic        letter;
    logic        digit;
    logic        space;
    logic [31:0] here;
    n = 0;
    open_run = (run_mode == stt_pkg::MODE_ALPHA) || (run_mode == stt_pkg::MODE_DIGIT);
    letter = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    digit = (b >= "0" && b <= "9");
    space = (b == " ") || (b >= 8'd9 && b <= 8'd13);
    here = byte_pos;
    if (eot) begin
      if (open_run) begin
        made[n] = close_run();
        n++;
      end
      run_mode = stt_pkg::MODE_IDLE;
    end else begin
      byte_pos = byte_pos + 32'd1;
      if (open_run && ((run_mode == stt_pkg::MODE_ALPHA && letter) ||
                       (run_mode == stt_pkg::MODE_DIGIT && digit))) begin
        grow_run(b);
      end else begin
        // The byte that ends a run is handled on its own in the same beat.
        if (open_run) begin
          made[n] = close_run();
          n++;
        end
        run_mode = stt_pkg::MODE_IDLE;
        if (letter || digit) begin
          run_mode = letter ? stt_pkg::MODE_ALPHA : stt_pkg::MODE_DIGIT;
          run_len = '0;
          run_over = 1'b0;
          run_start = here;
          grow_run(b);
        end else if (!space) begin
          made[n] = single_char(b, here);
          n++;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      made[i].last = (i == n - 1);
      predicted_tokens.push_back(made[i]);
    end
  endtask

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  task automatic match_token();
    token_t want;
    tokens_seen++;
    if (predicted_tokens.size() == 0) begin
      $display("%0t: token with nothing expected, expected none, actual kind %0d at %0d",
               $time, token_kind, start_pos);
      mismatch_count++;
    end else begin
      want = predicted_tokens.pop_front();
      check_field("token_kind", 64'(want.kind), 64'(token_kind));
      check_field("start_pos", 64'(want.pos), 64'(start_pos));
      check_field("token_length", 64'(want.len), 64'(token_length));
      check_field("text_head", want.head, text_head);
      check_field("truncated", 64'(want.trunc), 64'(truncated));
      check_field("last_of_run", 64'(want.last), 64'(last_of_run));
      kinds_seen = kinds_seen | (14'd1 << want.kind);
      if (want.trunc) long_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      run_mode = stt_pkg::MODE_IDLE;
      run_len = '0;
      run_start = '0;
      byte_pos = '0;
      run_over = 1'b0;
      end_reported = 1'b0;
      kinds_seen = '0;
      predicted_tokens.delete();
    end else begin
      if (token_valid && token_ready) match_token();
      if (text_valid && text_ready) begin
        beats_seen++;
        if (end_of_text) eot_seen++;
        tokenize_beat(text_byte, end_of_text);
      end
      if (run_done && !end_reported) begin
        end_reported = 1'b1;
        if (predicted_tokens.size() != 0) begin
          $display("%0t: tokens never delivered, expected 0 left, actual %0d left",
                   $time, predicted_tokens.size());
          mismatch_count++;
        end
      end
    end
    tokens_pending = predicted_tokens.size();
  end

endmodule

[tb/sv/tb_top.sv]
// Top of the tokenizer testbench: clock, reset, text stimulus, token sink and verdict.
`timescale 1ns / 1ps

module tb_top;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  text_byte = '0;
  logic        end_of_text = 1'b0;
  logic        text_valid = 1'b0;
  logic        text_ready;
  logic        token_valid;
  logic        token_ready = 1'b0;
  logic [3:0]  token_kind;
  logic [31:0] start_pos;
  logic [4:0]  token_length;
  logic [63:0] text_head;
  logic        truncated;
  logic        last_of_run;
  logic        run_done = 1'b0;

  int unsigned mismatch_count;
  int unsigned tokens_pending;
  int unsigned beats_seen;
  int unsigned eot_seen;
  int unsigned tokens_seen;
  int unsigned long_seen;
  logic [13:0] kinds_seen;

  localparam logic [7:0] SPACE_BYTES [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
  localparam logic [7:0] PUNCT_BYTES [7] = '{"=", "(", ")", "{", "}", ",", ";"};
  string keyword_list [5] = '{"int", "void", "print", "main", "return"};

  int unsigned beats_sent = 0;
  int unsigned sender_span = 0;
  bit          sender_calm = 1'b0;
  bit          drained_once = 1'b0;
  int unsigned sink_span = 0;
  int unsigned sink_hold = 0;
  bit          sink_calm = 1'b0;
  int unsigned sink_roll;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  source_text_tokenizer i_dut (
    .clk          (clk),
    .rst          (rst),
    .text_byte    (text_byte),
    .end_of_text  (end_of_text),
    .text_valid   (text_valid),
    .text_ready   (text_ready),
    .token_valid  (token_valid),
    .token_ready  (token_ready),
    .token_kind   (token_kind),
    .start_pos    (start_pos),
    .token_length (token_length),
    .text_head    (text_head),
    .truncated    (truncated),
    .last_of_run  (last_of_run)
  );

  token_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .text_byte      (text_byte),
    .end_of_text    (end_of_text),
    .text_valid     (text_valid),
    .text_ready     (text_ready),
    .token_valid    (token_valid),
    .token_ready    (token_ready),
    .token_kind     (token_kind),
    .start_pos      (start_pos),
    .token_length   (token_length),
    .text_head      (text_head),
    .truncated      (truncated),
    .last_of_run    (last_of_run),
    .run_done       (run_done),
    .mismatch_count (mismatch_count),
    .tokens_pending (tokens_pending),
    .beats_seen     (beats_seen),
    .eot_seen       (eot_seen),
    .tokens_seen    (tokens_seen),
    .long_seen      (long_seen),
    .kinds_seen     (kinds_seen)
  );

  // Token sink: alternates between stretches that take every token once any earlier
  // stall has run out and stretches with short and occasional long stalls.
  always @(negedge clk) begin
    if (sink_span == 0) begin
      sink_calm = ($urandom_range(0, 3) == 0);
      sink_span = $urandom_range(30, 120);
    end
    sink_span--;
    if (sink_hold != 0) begin
      sink_hold--;
      token_ready <= 1'b0;
    end else if (sink_calm) begin
      token_ready <= 1'b1;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 65) begin
        token_ready <= 1'b1;
      end else begin
        token_ready <= 1'b0;
        sink_hold = (sink_roll < 93) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic eot);
    int unsigned roll;
    int unsigned gap;
    if (sender_span == 0) begin
      sender_calm = ($urandom_range(0, 3) == 0);
      sender_span = $urandom_range(20, 80);
    end
    sender_span--;
    roll = $urandom_range(0, 99);
    gap = 0;
    if (!sender_calm) begin
      if (roll >= 90) gap = $urandom_range(8, 40);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      @(negedge clk);
      text_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    text_valid <= 1'b1;
    text_byte <= b;
    end_of_text <= eot;
    do @(posedge clk); while (!text_ready);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic send_word(input int unsigned count);
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 51);
      send_beat((r < 26) ? 8'("a" + r) : 8'("A" + r - 26), 1'b0);
    end
  endtask

  task automatic send_digits(input int unsigned count);
    for (int i = 0; i < count; i++) send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
  endtask

  // Mostly program-like text with keywords, names, numbers and punctuation, often
  // packed without spaces, plus some stray bytes and end-of-text beats.
  task automatic send_segment();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) send_text(keyword_list[$urandom_range(0, 4)]);
    else if (roll < 45) send_word($urandom_range(1, 8));
    else if (roll < 51) send_word($urandom_range(14, 40));
    else if (roll < 58) send_digits($urandom_range(1, 6));
    else if (roll < 61) send_digits($urandom_range(14, 35));
    else if (roll < 79) send_beat(PUNCT_BYTES[$urandom_range(0, 6)], 1'b0);
    else if (roll < 87) send_beat(SPACE_BYTES[$urandom_range(0, 5)], 1'b0);
    else if (roll < 95) send_beat(8'($urandom_range(0, 255)), 1'b0);
    else send_beat(8'($urandom_range(0, 255)), 1'b1);
    if ($urandom_range(0, 99) < 35) send_beat(SPACE_BYTES[$urandom_range(0, 5)], 1'b0);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    text_valid <= 1'b0;
    while (tokens_pending != 0) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    send_text("int main(){print=9,void;}");
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_text("\tab");
    send_beat(8'hFF, 1'b1);

    while (beats_sent < 1000) begin
      if (!drained_once && beats_sent >= 500) begin
        wait_for_drain();
        drained_once = 1'b1;
      end
      send_segment();
    end
    send_beat(8'h00, 1'b1);
    wait_for_drain();
    repeat (20) @(negedge clk);
    run_done <= 1'b1;
    repeat (2) @(negedge clk);

    $display("Fed %0d text beats, %0d of them end-of-text, and compared %0d tokens.",
             beats_seen, eot_seen, tokens_seen);
    $display("Token kinds reached: %0d of 14; truncated runs: %0d.",
             $countones(kinds_seen), long_seen);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1_500_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
